// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the PID controller.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PCDC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define PCDC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/pcdc_pkg.sv
// Shared types and constants of the PID controller with deadzone and clamps.
// No dependencies; every RTL module imports this package.
package pcdc_pkg;

	// Sequencer states of the controller.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PRE,
		ST_MUL_P,
		ST_MUL_S,
		ST_SUM,
		ST_MUL_IH,
		ST_MUL_IL,
		ST_MUL_D,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_TOTAL,
		ST_FIN
	} pcdc_state_t;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_GAIN_PROP   = 3'd0;
	localparam logic [2:0] REG_GAIN_INTEG  = 3'd1;
	localparam logic [2:0] REG_GAIN_DERIV  = 3'd2;
	localparam logic [2:0] REG_DRIVE_LIM   = 3'd3;
	localparam logic [2:0] REG_INTEG_LIM   = 3'd4;
	localparam logic [2:0] REG_DEAD_BAND   = 3'd5;
	localparam logic [2:0] REG_RETARGET    = 3'd6;

	// Reset values of the limit registers (100.0 and about 0.01 in Q16.16).
	localparam logic [30:0] DRIVE_LIM_RST = 31'd6553600;
	localparam logic [30:0] INTEG_LIM_RST = 31'd6553600;
	localparam logic [30:0] RETARGET_RST  = 31'd655;

	// Divider geometry.
	localparam int DIVIDEND_W = 64;
	localparam int DIVISOR_W  = 16;

	// Status of the divider as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: rtl/pid_controller_deadzone_clamp_unit.sv
// PID controller with deadzone, retarget clear and clamped integral and output.
// Depends on pcdc_pkg, pcdc_mul, pcdc_div and assert_macros.svh.
// An accepted input word runs through the pre, multiply, sum, divide, total and finish states.
// A new word is taken only once the last has been loaded to the output; the radix-4 divider is the longest step.
// A word inside the deadzone goes from the pre state straight to the finish state.
// Reset: asynchronous, active low; clears the sequencer, output valid and history and restores register defaults.
`include "assert_macros.svh"
module pid_controller_deadzone_clamp_unit import pcdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel.
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] measured,
	input  logic signed [31:0] setpoint,
	input  logic [15:0]        step_time,
	// Output channel.
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] drive,
	output logic               in_dead_band,
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers.
	logic signed [31:0] gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [30:0]        drive_lim_q, integ_lim_q, dead_band_q, retarget_q;

	// Controller state kept between words.
	logic signed [31:0] held_q;
	logic signed [31:0] last_err_q;
	logic signed [47:0] sum_q;

	// Working registers of one word.
	pcdc_state_t        state_q, state_d;
	logic signed [31:0] meas_q, sp_q;
	logic [15:0]        dt_q;
	logic signed [31:0] e_q;
	logic signed [48:0] p_q;
	logic signed [31:0] i_q;
	logic [63:0]        ih_q;
	logic               dneg_q;
	logic signed [31:0] res_drive_q;
	logic               res_dead_q;
	logic               out_valid_q;

	// Shared multiplier and divider.
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        prod_q;
	logic               div_start;
	logic [15:0]        div_dsr;
	logic [63:0]        quot_q;
	div_stat_t          div_stat;
	logic               fin_load;
	logic               cfg_wr;

	pcdc_mul u_mul (
		.clk    (clk),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.prod_q (prod_q)
	);

	pcdc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (div_dsr),
		.quot_q   (quot_q),
		.stat     (div_stat)
	);

	// Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	// ---------------------------------------------------------------------
	// Configuration port. Writes land in the access phase; reads are combinational.
	// ---------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= '0;
			gain_integ_q <= '0;
			gain_deriv_q <= '0;
			drive_lim_q  <= DRIVE_LIM_RST;
			integ_lim_q  <= INTEG_LIM_RST;
			dead_band_q  <= '0;
			retarget_q   <= RETARGET_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_GAIN_PROP:  gain_prop_q  <= pwdata;
				REG_GAIN_INTEG: gain_integ_q <= pwdata;
				REG_GAIN_DERIV: gain_deriv_q <= pwdata;
				REG_DRIVE_LIM:  drive_lim_q  <= pwdata[30:0];
				REG_INTEG_LIM:  integ_lim_q  <= pwdata[30:0];
				REG_DEAD_BAND:  dead_band_q  <= pwdata[30:0];
				REG_RETARGET:   retarget_q   <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_GAIN_PROP:  prdata = gain_prop_q;
			REG_GAIN_INTEG: prdata = gain_integ_q;
			REG_GAIN_DERIV: prdata = gain_deriv_q;
			REG_DRIVE_LIM:  prdata = {1'b0, drive_lim_q};
			REG_INTEG_LIM:  prdata = {1'b0, integ_lim_q};
			REG_DEAD_BAND:  prdata = {1'b0, dead_band_q};
			REG_RETARGET:   prdata = {1'b0, retarget_q};
			default:        prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Datapath helpers.
	// ---------------------------------------------------------------------
	logic signed [32:0] sp_diff, e_wide, err_diff;
	logic [32:0]        sp_diff_mag;
	logic signed [31:0] e_sat;
	logic [47:0]        sum_mag;
	logic [31:0]        diff_mag;

	// The retarget test compares the setpoint step against the held setpoint.
	assign sp_diff     = 33'(sp_q) - 33'(held_q);
	assign sp_diff_mag = sp_diff[32] ? 33'(-sp_diff) : 33'(sp_diff);

	// The error is saturated to the signed 32-bit range.
	assign e_wide = 33'(sp_q) - 33'(meas_q);
	always_comb begin
		if (e_wide > 33'sh0_7FFF_FFFF) begin
			e_sat = 32'sh7FFF_FFFF;
		end else if (e_wide < -33'sh0_8000_0000) begin
			e_sat = 32'sh8000_0000;
		end else begin
			e_sat = e_wide[31:0];
		end
	end

	assign sum_mag  = sum_q[47] ? 48'(-sum_q) : 48'(sum_q);
	assign err_diff = 33'(e_q) - 33'(last_err_q);
	assign diff_mag = err_diff[32] ? 32'(-err_diff) : err_diff[31:0];

	// ---------------------------------------------------------------------
	// Sequencer: next state.
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_PRE;
			ST_PRE: begin
				if ({1'b0, mag32(e_sat)} < {2'b0, dead_band_q}) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_MUL_P;
				end
			end
			ST_MUL_P:    state_d = ST_MUL_S;
			ST_MUL_S:    state_d = ST_SUM;
			ST_SUM:      state_d = ST_MUL_IH;
			ST_MUL_IH:   state_d = ST_MUL_IL;
			ST_MUL_IL:   state_d = ST_MUL_D;
			ST_MUL_D:    state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_stat.done) state_d = ST_TOTAL;
			ST_TOTAL:    state_d = ST_FIN;
			ST_FIN:      if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: outputs. The multiplier operands are chosen per state.
	// ---------------------------------------------------------------------
	always_comb begin
		in_ready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		fin_load  = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_MUL_P: begin
				mul_a = mag32(gain_prop_q);
				mul_b = mag32(e_q);
			end
			ST_MUL_S: begin
				mul_a = mag32(e_q);
				mul_b = {16'b0, dt_q};
			end
			ST_MUL_IH: begin
				mul_a = mag32(gain_integ_q);
				mul_b = {8'b0, sum_mag[47:24]};
			end
			ST_MUL_IL: begin
				mul_a = mag32(gain_integ_q);
				mul_b = {8'b0, sum_mag[23:0]};
			end
			ST_MUL_D: begin
				mul_a = mag32(gain_deriv_q);
				mul_b = diff_mag;
			end
			ST_DIV_GO: div_start = 1'b1;
			ST_FIN:    fin_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// A zero time step divides by one.
	assign div_dsr = (dt_q == 16'd0) ? 16'd1 : dt_q;

	// ---------------------------------------------------------------------
	// Result arithmetic that is consumed one product at a time.
	// ---------------------------------------------------------------------
	logic signed [48:0] step_s;
	logic signed [48:0] sum_next;
	logic [63:0]        i_mag;
	logic [30:0]        i_clamped;
	logic [48:0]        d_mag;
	logic signed [49:0] d_val;
	logic signed [51:0] total;
	logic signed [51:0] lim_wide;
	logic signed [31:0] drive_clamped;

	always_comb begin
		// The integration step carries the sign of the error, dt is unsigned.
		step_s   = e_q[31] ? -49'(prod_q[47:16]) : 49'(prod_q[47:16]);
		sum_next = 49'(sum_q) + step_s;

		// Integral term magnitude: high partial product was shifted up by 8.
		i_mag     = ih_q + {16'b0, prod_q[63:16]};
		i_clamped = (i_mag > {33'b0, integ_lim_q}) ? integ_lim_q : i_mag[30:0];

		// The derivative magnitude is capped at 2^48.
		d_mag = (quot_q > 64'h0001_0000_0000_0000) ? 49'h1_0000_0000_0000 : quot_q[48:0];
		d_val = dneg_q ? -50'(d_mag) : 50'(d_mag);

		total    = 52'(p_q) + 52'(i_q) + 52'(d_val);
		lim_wide = 52'(drive_lim_q);
		if (total > lim_wide) begin
			drive_clamped = 32'(lim_wide);
		end else if (total < -lim_wide) begin
			drive_clamped = 32'(-lim_wide);
		end else begin
			drive_clamped = total[31:0];
		end
	end

	// ---------------------------------------------------------------------
	// Control registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			held_q      <= '0;
			last_err_q  <= '0;
			sum_q       <= '0;
		end else begin
			state_q <= state_d;
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_PRE: begin
					// A large setpoint step clears the history before the error is used.
					held_q <= sp_q;
					if (sp_diff_mag > {2'b0, retarget_q}) begin
						last_err_q <= '0;
						sum_q      <= '0;
					end
				end
				ST_SUM: begin
					if (sum_next > 49'sh0_7FFF_FFFF_FFFF) begin
						sum_q <= 48'sh7FFF_FFFF_FFFF;
					end else if (sum_next < -49'sh0_8000_0000_0000) begin
						sum_q <= 48'sh8000_0000_0000;
					end else begin
						sum_q <= sum_next[47:0];
					end
				end
				ST_MUL_D: last_err_q <= e_q;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			meas_q <= measured;
			sp_q   <= setpoint;
			dt_q   <= step_time;
		end
		case (state_q)
			ST_PRE: begin
				e_q         <= e_sat;
				res_drive_q <= '0;
				res_dead_q  <= 1'b1;
			end
			ST_MUL_S: begin
				p_q <= (gain_prop_q[31] ^ e_q[31]) ? -49'(prod_q[63:16])
					: 49'(prod_q[63:16]);
			end
			ST_MUL_IL: ih_q <= {prod_q[55:0], 8'b0};
			ST_MUL_D: begin
				i_q    <= (gain_integ_q[31] ^ sum_q[47]) ? -32'(i_clamped) : 32'(i_clamped);
				dneg_q <= gain_deriv_q[31] ^ err_diff[32];
			end
			ST_TOTAL: begin
				res_drive_q <= drive_clamped;
				res_dead_q  <= 1'b0;
			end
			default: ;
		endcase
		if (fin_load) begin
			drive        <= res_drive_q;
			in_dead_band <= res_dead_q;
		end
	end

	assign out_valid = out_valid_q;

	// ---------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------
	logic signed [31:0] drive_lim_s;
	assign drive_lim_s = $signed({1'b0, drive_lim_q});

	`PCDC_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")
	`PCDC_ASSERT(a_dead_band_zero, !(out_valid && in_dead_band) || drive == 32'sd0, "deadzone drive")
	`PCDC_ASSERT(a_drive_in_limit, !out_valid || (drive <= drive_lim_s && drive >= -drive_lim_s), "drive beyond limit")
	`PCDC_ASSERT(a_div_idle, state_q != ST_IDLE || !div_stat.busy, "divider busy while idle")

endmodule

// File: rtl/pcdc_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on pcdc_pkg.
module pcdc_mul import pcdc_pkg::*; (
	input  logic        clk,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 64'(op_a) * 64'(op_b);
	end

endmodule

// File: rtl/pcdc_div.sv
// Restoring divider, 64-bit dividend by 16-bit divisor, two quotient bits a cycle.
// Depends on pcdc_pkg for widths and the status struct.
module pcdc_div import pcdc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quot_q,
	output div_stat_t             stat
);

	localparam int STEPS = DIVIDEND_W / 2;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W-1:0]  rem_d;
	logic [DIVIDEND_W-1:0] quot_d;

	// Two dependent shift-compare-subtract steps on the 17-bit partial remainder.
	always_comb begin
		logic [DIVISOR_W:0] trial;
		rem_d  = rem_q;
		quot_d = quot_q;
		for (int k = 0; k < 2; k++) begin
			trial  = {rem_d, quot_d[DIVIDEND_W-1]};
			quot_d = {quot_d[DIVIDEND_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_d     = DIVISOR_W'(trial - {1'b0, dsr_q});
				quot_d[0] = 1'b1;
			end else begin
				rem_d = trial[DIVISOR_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= quot_d;
			rem_q  <= rem_d;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: tb/sv/pcdc_checker.sv
// Checker for the PID controller: watches both word channels and the register port.
// Depends on pcdc_pkg for the register indexes; keeps its own model of the controller.
`timescale 1ns / 1ps
module pcdc_checker import pcdc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] measured,
	input  logic signed [31:0] setpoint,
	input  logic [15:0]        step_time,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] drive,
	input  logic               in_dead_band,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 words_waiting,
	output int                 words_checked,
	output int                 dead_words
);

	typedef struct packed {
		logic signed [31:0] drive;
		logic               dead;
	} drive_word_t;

	localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_MIN = -64'sh0000_8000_0000_0000;
	localparam longint unsigned D_CAP = 64'h0001_0000_0000_0000;

	drive_word_t drive_q[$];

	// Shadow registers and controller state.
	longint kp, ki, kd, out_lim, i_lim, band, retarget;
	longint prev_err, err_acc, tgt_held;

	function automatic longint unsigned absval(input longint v);
		return v < 0 ? 64'd0 - longint'(unsigned'(v)) : longint'(unsigned'(v));
	endfunction

	function automatic longint signed_mag(input longint unsigned m, input logic neg);
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q16_mul(input longint a, input longint b);
		longint unsigned m;
		m = (absval(a) * absval(b)) >> 16;
		return signed_mag(m, (a < 0) != (b < 0));
	endfunction

	function automatic drive_word_t next_drive(input logic signed [31:0] meas,
			input logic signed [31:0] tgt, input logic [15:0] dt);
		drive_word_t w;
		longint e, p, iterm, d, total, diff;
		longint unsigned a, b, m, q, div;
		if (absval(longint'(tgt) - tgt_held) > longint'(unsigned'(retarget))) begin
			prev_err = 0;
			err_acc = 0;
		end
		tgt_held = tgt;
		e = longint'(tgt) - longint'(meas);
		if (e > 64'sd2147483647) e = 64'sd2147483647;
		if (e < -64'sd2147483648) e = -64'sd2147483648;
		// Inside the dead band the state is left alone and the drive is zero.
		if (absval(e) < longint'(unsigned'(band))) begin
			w.drive = '0;
			w.dead = 1'b1;
			return w;
		end
		p = q16_mul(kp, e);
		err_acc = err_acc + q16_mul(e, longint'({48'd0, dt}));
		if (err_acc > SUM_MAX) err_acc = SUM_MAX;
		if (err_acc < SUM_MIN) err_acc = SUM_MIN;
		a = absval(ki);
		b = absval(err_acc);
		m = ((a * (b >> 24)) << 8) + ((a * (b & 64'hFF_FFFF)) >> 16);
		if (m > longint'(unsigned'(i_lim))) m = i_lim;
		iterm = signed_mag(m, (ki < 0) != (err_acc < 0));
		diff = e - prev_err;
		div = (dt == 16'd0) ? 64'd1 : {48'd0, dt};
		q = (absval(kd) * absval(diff)) / div;
		if (q > D_CAP) q = D_CAP;
		d = signed_mag(q, (kd < 0) != (diff < 0));
		prev_err = e;
		total = p + iterm + d;
		if (total > out_lim) total = out_lim;
		if (total < -out_lim) total = -out_lim;
		w.drive = total[31:0];
		w.dead = 1'b0;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		drive_word_t exp_w;
		if (!arst_n) begin
			kp = 0; ki = 0; kd = 0;
			out_lim = 6553600; i_lim = 6553600; band = 0; retarget = 655;
			prev_err = 0; err_acc = 0; tgt_held = 0;
			drive_q.delete();
			fail_count = 0; words_waiting = 0; words_checked = 0; dead_words = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_GAIN_PROP:  kp = longint'($signed(pwdata));
					REG_GAIN_INTEG: ki = longint'($signed(pwdata));
					REG_GAIN_DERIV: kd = longint'($signed(pwdata));
					REG_DRIVE_LIM:  out_lim = {33'd0, pwdata[30:0]};
					REG_INTEG_LIM:  i_lim = {33'd0, pwdata[30:0]};
					REG_DEAD_BAND:  band = {33'd0, pwdata[30:0]};
					REG_RETARGET:   retarget = {33'd0, pwdata[30:0]};
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (drive_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected output word drive=%0d dead=%0b",
						$time, drive, in_dead_band);
				end else begin
					exp_w = drive_q.pop_front();
					words_checked++;
					if (exp_w.dead) dead_words++;
					if (drive !== exp_w.drive) begin
						fail_count++;
						$display("%0t: drive expected %0d actual %0d",
							$time, exp_w.drive, drive);
					end
					if (in_dead_band !== exp_w.dead) begin
						fail_count++;
						$display("%0t: in_dead_band expected %0b actual %0b",
							$time, exp_w.dead, in_dead_band);
					end
				end
			end
			if (in_valid && in_ready)
				drive_q.push_back(next_drive(measured, setpoint, step_time));
			words_waiting = drive_q.size();
		end
	end

endmodule

// File: tb/sv/tb_pid_controller_deadzone_clamp_unit.sv
// Top of the PID controller testbench: clock, reset, stimulus and verdict.
// Depends on pcdc_pkg, the controller RTL and pcdc_checker.
`timescale 1ns / 1ps
module tb_pid_controller_deadzone_clamp_unit;
	import pcdc_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic signed [31:0] measured = '0;
	logic signed [31:0] setpoint = '0;
	logic [15:0]        step_time = 16'd1;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [31:0] drive;
	logic               in_dead_band;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int fail_count, words_waiting, words_checked, dead_words;
	int words_sent = 0;
	int phases_run = 0;

	// The target that well-formed sequences track, and the current retarget step.
	logic signed [31:0] cur_target = '0;
	int                 cur_retarget = 655;

	// Receiver pressure: 0 always ready, 1 random short stalls with rare long ones.
	int stall_mode = 0;
	int stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pid_controller_deadzone_clamp_unit u_top (.*);

	pcdc_checker u_chk (.*);

	// The output side: ready follows the stall mode, with long stalls now and then.
	always @(posedge clk) begin
		if (stall_mode == 0) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 3) begin
			stall_left <= $urandom_range(10, 80);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 65);
		end
	end

	// Writes one register through a setup and an access phase. The bus is left
	// selected so that writes can follow each other directly.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	// A new setting is only loaded once every expected word has come back.
	task automatic load_setting(input logic [31:0] kp, ki, kd, out_lim, i_lim, band, rt);
		in_valid <= 1'b0;
		@(posedge clk);
		wait (words_waiting == 0);
		repeat (50) @(posedge clk);
		write_reg(REG_GAIN_PROP, kp);
		write_reg(REG_GAIN_INTEG, ki);
		write_reg(REG_GAIN_DERIV, kd);
		write_reg(REG_DRIVE_LIM, out_lim);
		write_reg(REG_INTEG_LIM, i_lim);
		write_reg(REG_DEAD_BAND, band);
		write_reg(REG_RETARGET, rt);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_retarget = int'(rt[30:0]);
		phases_run++;
	endtask

	// Offers one word and holds it until it is taken, then sometimes idles for a random gap.
	task automatic send_word(input logic signed [31:0] meas, tgt, input logic [15:0] dt);
		int gap;
		in_valid <= 1'b1;
		measured <= meas;
		setpoint <= tgt;
		step_time <= dt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		words_sent++;
		gap = ($urandom_range(0, 99) < 50) ? 0 :
			($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Mostly a loop tracking a steady target with small errors, sometimes a retarget; also
	// words with a random measurement and extreme step times, and fully random words.
	task automatic send_random_word();
		int kind;
		logic signed [31:0] meas, tgt;
		logic [15:0] dt;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			if ($urandom_range(0, 99) < 8)
				cur_target = 32'($urandom_range(0, 32'h00FF_FFFF) - 32'sh0080_0000);
			else if ($urandom_range(0, 99) < 20 && cur_retarget < 32'h1000_0000)
				cur_target = 32'(cur_target + $urandom_range(0, cur_retarget)
					- cur_retarget / 2);
			tgt = cur_target;
			meas = 32'(tgt + ($urandom_range(0, 32'h0010_0000) - 32'sh0008_0000));
			dt = 16'($urandom_range(1, 2000));
		end else if (kind < 85) begin
			tgt = cur_target;
			meas = $urandom;
			dt = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 3))
				: 16'($urandom_range(60000, 65535));
		end else begin
			tgt = $urandom;
			meas = $urandom;
			dt = 16'($urandom);
			cur_target = tgt;
		end
		send_word(meas, tgt, dt);
	endtask

	task automatic run_phase(input int count);
		repeat (count) send_random_word();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: moderate gains, a small dead band and the default retarget step.
		load_setting(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000,
			32'h0064_0000, 32'h0000_0100, 32'd655);
		send_word(32'sh7FFF_FFFF, 32'sh8000_0000, 16'd1);   // error saturates low
		send_word(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd65535); // error saturates high
		send_word(32'sd0, 32'sd0, 16'd100);                 // zero error in the dead band
		send_word(32'sd0, 32'sd0, 16'd0);                   // zero step time
		send_word(32'sd5, 32'sd655, 16'd10);                // target moves exactly the step
		send_word(32'sd5, 32'sd1311, 16'd10);               // one past the step clears state
		send_word(32'sd1311 - 32'sd255, 32'sd1311, 16'd10); // just inside the dead band
		send_word(32'sd1311 - 32'sd256, 32'sd1311, 16'd10); // exactly on the band edge
		send_word(32'sh8000_0000, 32'sh8000_0000, 16'd65535);
		send_word(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 16'd1);
		send_word(32'shFFFF_0000, 32'sh7FFF_FFFF, 16'd0);
		send_word(32'sh5555_5555, 32'shAAAA_AAAA, 16'h5555);
		send_word(32'shAAAA_AAAA, 32'sh5555_5555, 16'hAAAA);
		repeat (6) send_word(32'sh8000_0000, 32'sh7FFF_FFFF, 16'd65535); // sum grows by its largest step

		// Extremes of the registers.
		load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
		run_phase(80);
		load_setting(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0,
			32'd0, 32'd0);
		run_phase(60);
		load_setting(32'h0002_0000, 32'h0001_0000, 32'h0000_1000, 32'h7FFF_FFFF,
			32'h0000_8000, 32'h7FFF_FFFF, 32'd655);
		run_phase(60);

		// Random settings, with the receiver stalling in most of them.
		for (int ph = 0; ph < 9; ph++) begin
			stall_mode = (ph % 3 == 2) ? 0 : 1;
			load_setting($urandom_range(0, 32'h0008_0000) - 32'sh0004_0000,
				$urandom_range(0, 32'h0000_4000) - 32'sh0000_2000,
				$urandom_range(0, 32'h0004_0000) - 32'sh0002_0000,
				$urandom_range(0, 32'h0400_0000) | ($urandom_range(0, 1) << 31),
				$urandom_range(0, 32'h0200_0000),
				$urandom_range(0, 32'h0002_0000),
				$urandom_range(0, 32'h0004_0000));
			run_phase(150);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		wait (words_waiting == 0);
		repeat (50) @(posedge clk);

		$display("Sent %0d words over %0d register settings; %0d output words checked.",
			words_sent, phases_run, words_checked);
		$display("%0d of them fell in the dead band.", dead_words);
		if (fail_count == 0 && words_waiting == 0)
			$display("pid_controller_deadzone_clamp_unit test passed");
		else
			$display("pid_controller_deadzone_clamp_unit test failed");
		$finish;
	end

	// Guards against a hung handshake.
	initial begin
		#20ms;
		$display("Timeout with %0d words outstanding.", words_waiting);
		$display("pid_controller_deadzone_clamp_unit test failed");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/pcdc_pkg.sv
rtl/pcdc_mul.sv
rtl/pcdc_div.sv
rtl/pid_controller_deadzone_clamp_unit.sv
tb/sv/pcdc_checker.sv
tb/sv/tb_pid_controller_deadzone_clamp_unit.sv
